[rtl/core/ksl_pkg.sv]
`timescale 1ns / 1ps

package ksl_pkg;

    // fixed port widths
    localparam int OPCODE_W    = 3;
    localparam int KEY_IDENT_W = 32;
    localparam int KEY_VALUE_W = 64;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 5;

    // defaults for the top-level parameters
    localparam int SLOTS_DEF     = 16;
    localparam int KEY_BYTES_DEF = 8;
    localparam int ID_BITS_DEF   = 32;

    // a list reports at most this many keys
    localparam int MAX_RESULTS = 16;

    localparam logic [OPCODE_W-1:0] OP_INJECT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_GET    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LIST   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP_ID     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP_DATA   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY_DATA = 3'd5;

endpackage

[rtl/core/ksl_cell.sv]
`timescale 1ns / 1ps

module ksl_cell #(
    parameter int ID_BITS = 32,
    parameter int VAL_W   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  logic [ID_BITS-1:0] in_ident,
    input  logic [VAL_W-1:0]   in_value,
    output logic [ID_BITS-1:0] ident,
    output logic [VAL_W-1:0]   value
);

    logic [ID_BITS-1:0] ident_reg;
    logic [VAL_W-1:0]   value_reg;

    // zero ident marks the slot empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg <= '0;
        end
        else if (shift)
        begin
            ident_reg <= in_ident;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= in_value;
        end
    end

    assign ident = ident_reg;
    assign value = value_reg;

endmodule

[rtl/core/ksl_ring.sv]
`timescale 1ns / 1ps

module ksl_ring #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 32,
    parameter int VAL_W   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  logic [ID_BITS-1:0] feed_ident,
    input  logic [VAL_W-1:0]   feed_value,
    output logic [ID_BITS-1:0] head_ident,
    output logic [VAL_W-1:0]   head_value
);

    logic [ID_BITS-1:0] ident_w [SLOTS];
    logic [VAL_W-1:0]   value_w [SLOTS];

    // cell i takes from cell i+1; the tail takes the (possibly edited) head
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic [ID_BITS-1:0] src_ident;
        logic [VAL_W-1:0]   src_value;

        if (i == SLOTS - 1)
        begin : g_tail
            assign src_ident = feed_ident;
            assign src_value = feed_value;
        end
        else
        begin : g_body
            assign src_ident = ident_w[i+1];
            assign src_value = value_w[i+1];
        end

        ksl_cell #(
            .ID_BITS (ID_BITS),
            .VAL_W   (VAL_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .in_ident (src_ident),
            .in_value (src_value),
            .ident    (ident_w[i]),
            .value    (value_w[i])
        );
    end

    assign head_ident = ident_w[0];
    assign head_value = value_w[0];

endmodule

[rtl/core/key_slot_table_unit.sv]
`timescale 1ns / 1ps

// Key slot table. The slots sit in a ring of cells that, while a request is being
// served, rotates one slot per cycle past a head cell, where the controller reads
// and edits them. A request is taken when start is high and busy is low. Invalid
// identifiers, unknown opcodes and inject into a full table answer on the next
// cycle. Erase, update, get, list and rejected injects rotate the ring once and
// answer after that rotation; a successful inject rotates it a second time to
// write the first empty slot and answers when that second rotation ends.
// List results stream out during the rotation, one key behind the scan: a key
// goes out when the next occupied slot reaches the head, and the final one
// follows the scan, marked by last. Each result is on the ports for one cycle
// with result_valid high and must be taken then.
module key_slot_table_unit
#(
    parameter int SLOTS     = ksl_pkg::SLOTS_DEF,
    parameter int KEY_BYTES = ksl_pkg::KEY_BYTES_DEF,
    parameter int ID_BITS   = ksl_pkg::ID_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ksl_pkg::OPCODE_W-1:0]     opcode,
    input  logic [ksl_pkg::KEY_IDENT_W-1:0]  key_ident,
    input  logic [ksl_pkg::KEY_VALUE_W-1:0]  key_value,
    output logic                             result_valid,
    output logic [ksl_pkg::STATUS_W-1:0]     status,
    output logic                             found,
    output logic [ksl_pkg::KEY_IDENT_W-1:0]  out_ident,
    output logic [ksl_pkg::KEY_VALUE_W-1:0]  out_value,
    output logic [ksl_pkg::COUNT_W-1:0]      key_count,
    output logic                             last
);

    import ksl_pkg::*;

    localparam int VAL_W = 8 * KEY_BYTES;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int NUM_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE,
        S_COMMIT
    } state_t;

    state_t               state_reg;
    logic [OPCODE_W-1:0]  op_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [IDX_W-1:0]     step_reg;
    logic [IDX_W-1:0]     tgt_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 hit_reg;
    logic                 empty_found_reg;
    logic                 dup_data_reg;
    logic [VAL_W-1:0]     get_value_reg;
    logic                 pend_reg;
    logic [ID_BITS-1:0]   pend_id_reg;
    logic [NUM_W-1:0]     num_reg;

    logic                 strobe_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 found_reg;
    logic [ID_BITS-1:0]   oid_reg;
    logic [VAL_W-1:0]     oval_reg;
    logic                 last_reg;

    logic                 shift;
    logic [ID_BITS-1:0]   feed_ident;
    logic [VAL_W-1:0]     feed_value;
    logic [ID_BITS-1:0]   head_ident;
    logic [VAL_W-1:0]     head_value;
    logic                 head_match;
    logic                 last_step;
    logic [ID_BITS-1:0]   id_in;
    logic [VAL_W-1:0]     val_in;

    ksl_ring #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS),
        .VAL_W   (VAL_W)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (shift),
        .feed_ident (feed_ident),
        .feed_value (feed_value),
        .head_ident (head_ident),
        .head_value (head_value)
    );

    assign id_in      = key_ident[ID_BITS-1:0];
    assign val_in     = key_value[VAL_W-1:0];
    assign head_match = (head_ident == id_reg);
    assign last_step  = (step_reg == IDX_W'(SLOTS - 1));
    assign shift      = (state_reg == S_SCAN) || (state_reg == S_COMMIT);

    // edits on the slot leaving the head
    always_comb
    begin
        feed_ident = head_ident;
        feed_value = head_value;
        if (state_reg == S_SCAN && head_match)
        begin
            case (op_reg)
                OP_ERASE:
                begin
                    feed_ident = '0;
                    feed_value = '0;
                end
                OP_UPDATE:
                begin
                    if (head_value != val_reg && val_reg != '0)
                    begin
                        feed_value = val_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_COMMIT && step_reg == tgt_reg)
        begin
            feed_ident = id_reg;
            feed_value = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_INJECT;
            id_reg          <= '0;
            val_reg         <= '0;
            step_reg        <= '0;
            tgt_reg         <= '0;
            count_reg       <= '0;
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
            dup_data_reg    <= 1'b0;
            get_value_reg   <= '0;
            pend_reg        <= 1'b0;
            pend_id_reg     <= '0;
            num_reg         <= '0;
            strobe_reg      <= 1'b0;
            status_reg      <= ST_OK;
            found_reg       <= 1'b0;
            oid_reg         <= '0;
            oval_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg          <= opcode;
                        id_reg          <= id_in;
                        val_reg         <= val_in;
                        step_reg        <= '0;
                        hit_reg         <= 1'b0;
                        empty_found_reg <= 1'b0;
                        dup_data_reg    <= 1'b0;
                        pend_reg        <= 1'b0;
                        num_reg         <= '0;
                        if (opcode == OP_LIST)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else if (!(opcode inside {OP_INJECT, OP_ERASE, OP_UPDATE, OP_GET})
                                 || id_in == '0)
                        begin
                            strobe_reg <= 1'b1;
                            status_reg <= ST_BAD_ID;
                            found_reg  <= 1'b0;
                            oid_reg    <= '0;
                            oval_reg   <= '0;
                            last_reg   <= 1'b1;
                        end
                        else if (opcode == OP_INJECT && count_reg == CNT_W'(SLOTS))
                        begin
                            strobe_reg <= 1'b1;
                            status_reg <= ST_FULL;
                            found_reg  <= 1'b0;
                            oid_reg    <= '0;
                            oval_reg   <= '0;
                            last_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_DONE;
                    end
                    case (op_reg)
                        OP_LIST:
                        begin
                            // hold one key back so the final one can be marked
                            if (head_ident != '0 && num_reg != NUM_W'(MAX_RESULTS))
                            begin
                                if (pend_reg)
                                begin
                                    strobe_reg <= 1'b1;
                                    status_reg <= ST_OK;
                                    found_reg  <= 1'b1;
                                    oid_reg    <= pend_id_reg;
                                    oval_reg   <= '0;
                                    last_reg   <= 1'b0;
                                end
                                pend_reg    <= 1'b1;
                                pend_id_reg <= head_ident;
                                num_reg     <= num_reg + 1'b1;
                            end
                        end
                        OP_INJECT:
                        begin
                            if (head_ident == '0 && !empty_found_reg)
                            begin
                                empty_found_reg <= 1'b1;
                                tgt_reg         <= step_reg;
                            end
                            if (head_match)
                            begin
                                hit_reg <= 1'b1;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (head_match)
                            begin
                                hit_reg   <= 1'b1;
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (head_match)
                            begin
                                hit_reg      <= 1'b1;
                                dup_data_reg <= (head_value == val_reg);
                            end
                        end
                        OP_GET:
                        begin
                            if (head_match)
                            begin
                                hit_reg       <= 1'b1;
                                get_value_reg <= head_value;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                S_DONE:
                begin
                    state_reg  <= S_IDLE;
                    strobe_reg <= 1'b1;
                    status_reg <= ST_OK;
                    found_reg  <= 1'b0;
                    oid_reg    <= '0;
                    oval_reg   <= '0;
                    last_reg   <= 1'b1;
                    case (op_reg)
                        OP_LIST:
                        begin
                            if (pend_reg)
                            begin
                                found_reg <= 1'b1;
                                oid_reg   <= pend_id_reg;
                            end
                        end
                        OP_INJECT:
                        begin
                            if (hit_reg)
                            begin
                                status_reg <= ST_DUP_ID;
                            end
                            else if (val_reg == '0)
                            begin
                                status_reg <= ST_EMPTY_DATA;
                            end
                            else if (!empty_found_reg)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                strobe_reg <= 1'b0;
                                state_reg  <= S_COMMIT;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (hit_reg)
                            begin
                                oid_reg <= id_reg;
                            end
                            else
                            begin
                                status_reg <= ST_BAD_ID;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (!hit_reg)
                            begin
                                status_reg <= ST_BAD_ID;
                            end
                            else if (dup_data_reg)
                            begin
                                status_reg <= ST_DUP_DATA;
                            end
                            else if (val_reg == '0)
                            begin
                                status_reg <= ST_EMPTY_DATA;
                            end
                            else
                            begin
                                oid_reg <= id_reg;
                            end
                        end
                        OP_GET:
                        begin
                            if (hit_reg)
                            begin
                                found_reg <= 1'b1;
                                oid_reg   <= id_reg;
                                oval_reg  <= get_value_reg;
                            end
                            else
                            begin
                                status_reg <= ST_BAD_ID;
                            end
                        end
                        default:
                        begin
                            status_reg <= ST_BAD_ID;
                        end
                    endcase
                end

                S_COMMIT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                    begin
                        step_reg   <= '0;
                        state_reg  <= S_IDLE;
                        count_reg  <= count_reg + 1'b1;
                        strobe_reg <= 1'b1;
                        status_reg <= ST_OK;
                        found_reg  <= 1'b0;
                        oid_reg    <= id_reg;
                        oval_reg   <= '0;
                        last_reg   <= 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = strobe_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign out_ident    = KEY_IDENT_W'(oid_reg);
    assign out_value    = KEY_VALUE_W'(oval_reg);
    assign key_count    = COUNT_W'(count_reg);
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("key count above slot count");

    a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_LIST) |=> busy)
        else $error("list request did not start a scan");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final list result with no scan running");

    a_commit_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && !last_step) |=> !result_valid)
        else $error("result during inject write-back");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ksl_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 2 * SLOTS + 8;

    // opcodes the block does not implement
    localparam logic [OPCODE_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   found;
        logic [KEY_IDENT_W-1:0] ident;
        logic [KEY_VALUE_W-1:0] value;
        logic [COUNT_W-1:0]     count;
        logic                   last;
    } key_response_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [OPCODE_W-1:0]    opcode = OP_LIST;
    logic [KEY_IDENT_W-1:0] key_ident = '0;
    logic [KEY_VALUE_W-1:0] key_value = '0;
    logic                   busy;
    logic                   result_valid;
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [KEY_IDENT_W-1:0] out_ident;
    logic [KEY_VALUE_W-1:0] out_value;
    logic [COUNT_W-1:0]     key_count;
    logic                   last;

    // shadow copy of the table
    logic [KEY_IDENT_W-1:0] shadow_ident [SLOTS];
    logic [KEY_VALUE_W-1:0] shadow_value [SLOTS];
    int                     shadow_count;

    key_response_t pending_responses [$];
    int            error_count;
    int            cycle_count;
    int            idle_pct;

    key_slot_table_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .key_ident    (key_ident),
        .key_value    (key_value),
        .result_valid (result_valid),
        .status       (status),
        .found        (found),
        .out_ident    (out_ident),
        .out_value    (out_value),
        .key_count    (key_count),
        .last         (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, pending_responses.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int find_slot(input logic [KEY_IDENT_W-1:0] id);
        if (id == '0)
            return -1;
        for (int s = 0; s < SLOTS; s++)
            if (shadow_ident[s] == id)
                return s;
        return -1;
    endfunction

    // Works out the responses of one accepted request and updates the shadow table.
    function automatic void predict_response(input logic [OPCODE_W-1:0] op,
                                             input logic [KEY_IDENT_W-1:0] id,
                                             input logic [KEY_VALUE_W-1:0] val);
        key_response_t r;
        int            hit;
        int            free_slot;
        int            n;
        int            listed;

        r = '0;
        r.last = 1'b1;
        hit = find_slot(id);
        free_slot = -1;
        for (int s = SLOTS - 1; s >= 0; s--)
            if (shadow_ident[s] == '0)
                free_slot = s;

        if (op == OP_LIST)
        begin
            listed = (shadow_count < MAX_RESULTS) ? shadow_count : MAX_RESULTS;
            n = 0;
            for (int s = 0; s < SLOTS; s++)
            begin
                if (shadow_ident[s] != '0 && n < MAX_RESULTS)
                begin
                    r.status = ST_OK;
                    r.found  = 1'b1;
                    r.ident  = shadow_ident[s];
                    r.value  = '0;
                    r.count  = COUNT_W'(shadow_count);
                    r.last   = (n + 1 == listed);
                    pending_responses = {pending_responses, r};
                    n++;
                end
            end
            if (n == 0)
            begin
                r = '0;
                r.count = COUNT_W'(shadow_count);
                r.last  = 1'b1;
                pending_responses = {pending_responses, r};
            end
            return;
        end

        if (op > OP_LIST || id == '0)
            r.status = ST_BAD_ID;
        else if (op == OP_INJECT)
        begin
            // full takes priority over duplicate id, which beats empty data
            if (shadow_count >= SLOTS || free_slot < 0)
                r.status = ST_FULL;
            else if (hit >= 0)
                r.status = ST_DUP_ID;
            else if (val == '0)
                r.status = ST_EMPTY_DATA;
            else
            begin
                shadow_ident[free_slot] = id;
                shadow_value[free_slot] = val;
                shadow_count++;
                r.status = ST_OK;
                r.ident  = id;
            end
        end
        else if (hit < 0)
            r.status = ST_BAD_ID;
        else
        begin
            case (op)
                OP_ERASE:
                begin
                    shadow_ident[hit] = '0;
                    shadow_value[hit] = '0;
                    shadow_count--;
                    r.status = ST_OK;
                    r.ident  = id;
                end
                OP_UPDATE:
                begin
                    // unchanged data is checked before all-zero data
                    if (shadow_value[hit] == val)
                        r.status = ST_DUP_DATA;
                    else if (val == '0)
                        r.status = ST_EMPTY_DATA;
                    else
                    begin
                        shadow_value[hit] = val;
                        r.status = ST_OK;
                        r.ident  = id;
                    end
                end
                default:
                begin
                    r.status = ST_OK;
                    r.found  = 1'b1;
                    r.ident  = id;
                    r.value  = shadow_value[hit];
                end
            endcase
        end
        r.count = COUNT_W'(shadow_count);
        pending_responses = {pending_responses, r};
    endfunction

    always @(posedge clk)
    begin
        key_response_t got;
        key_response_t want;
        if (rst_n && result_valid)
        begin
            got = {status, found, out_ident, out_value, key_count, last};
            if (pending_responses.size() == 0)
            begin
                if (error_count < 10)
                    $display("%0t: response with nothing pending: status=%0d ident=%h",
                             $realtime, got.status, got.ident);
                error_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (got !== want)
                begin
                    if (error_count < 10)
                    begin
                        $display("%0t: response mismatch", $realtime);
                        $display("  exp status=%0d found=%0d ident=%h value=%h count=%0d last=%0d",
                                 want.status, want.found, want.ident, want.value,
                                 want.count, want.last);
                        $display("  got status=%0d found=%0d ident=%h value=%h count=%0d last=%0d",
                                 got.status, got.found, got.ident, got.value,
                                 got.count, got.last);
                    end
                    error_count++;
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic [KEY_IDENT_W-1:0] id,
                                input logic [KEY_VALUE_W-1:0] val);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(36, 1)) @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        key_ident <= id;
        key_value <= val;
        do
            @(posedge clk);
        while (busy);
        predict_response(op, id, val);
    endtask

    task automatic drain_responses();
        start <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_IDENT_W-1:0] fresh_ident();
        logic [KEY_IDENT_W-1:0] id;
        do
            id = $urandom();
        while (id == '0 || find_slot(id) >= 0);
        return id;
    endfunction

    function automatic logic [KEY_VALUE_W-1:0] random_value();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KEY_IDENT_W-1:0] pick_ident(input logic [OPCODE_W-1:0] op);
        int used [$];
        int roll;
        for (int s = 0; s < SLOTS; s++)
            if (shadow_ident[s] != '0)
                used = {used, s};
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (op == OP_INJECT && roll < 78)
            return fresh_ident();
        if (used.size() > 0 && (op != OP_INJECT || roll < 93) && roll < 80)
            return shadow_ident[used[$urandom_range(used.size() - 1)]];
        return $urandom();
    endfunction

    function automatic logic [KEY_VALUE_W-1:0] pick_value(input logic [OPCODE_W-1:0] op,
                                                          input logic [KEY_IDENT_W-1:0] id);
        int roll;
        int s;
        roll = $urandom_range(99);
        s = find_slot(id);
        if (roll < 8)
            return '0;
        if (op == OP_UPDATE && s >= 0 && roll < 28)
            return shadow_value[s];
        return random_value();
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_opcode();
        int roll;
        int inject_band;
        roll = $urandom_range(99);
        if (roll < 4)
            return OPCODE_W'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
        if (roll < 14)
            return OP_LIST;
        inject_band = (shadow_count < 4) ? 70 : (shadow_count == SLOTS) ? 30 : 46;
        if (roll < inject_band)
            return OP_INJECT;
        case ($urandom_range(2))
            0:       return OP_ERASE;
            1:       return OP_UPDATE;
            default: return OP_GET;
        endcase
    endfunction

    task automatic test_basic_commands();
        send_request(OP_LIST, '0, '0);
        send_request(OP_INJECT, '0, 64'd5);
        send_request(OP_ERASE, '0, '0);
        send_request(OP_UPDATE, '0, 64'd5);
        send_request(OP_GET, '0, '0);
        send_request(OP_INJECT, 32'd7, '0);
        send_request(OP_INJECT, '1, '1);
        send_request(OP_INJECT, 32'd1, 64'd1);
        send_request(OP_INJECT, '1, 64'd3);
        send_request(OP_GET, '1, '0);
        send_request(OP_GET, 32'd2, '0);
        send_request(OP_UPDATE, 32'd1, 64'd1);
        send_request(OP_UPDATE, 32'd1, '0);
        send_request(OP_UPDATE, 32'd1, 64'h8000_0000_0000_0000);
        send_request(OP_GET, 32'd1, '1);
        send_request(OP_UPDATE, 32'd2, 64'd9);
        send_request(OP_ERASE, 32'd2, '0);
        for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++)
            send_request(OPCODE_W'(op), 32'd1, 64'd1);
        send_request(OP_LIST, '1, '1);
        send_request(OP_ERASE, '1, '0);
        // the freed slot 0 is the first empty one again
        send_request(OP_INJECT, 32'h0000_5a5a, 64'h1234);
        send_request(OP_LIST, '0, '0);
        send_request(OP_INJECT, 32'd1, '0);
    endtask

    task automatic test_table_full();
        logic [KEY_IDENT_W-1:0] id;
        while (shadow_count < SLOTS)
            send_request(OP_INJECT, fresh_ident(), random_value());
        send_request(OP_INJECT, fresh_ident(), random_value());
        send_request(OP_INJECT, shadow_ident[SLOTS - 1], random_value());
        send_request(OP_INJECT, fresh_ident(), '0);
        send_request(OP_LIST, $urandom(), random_value());
        send_request(OP_GET, shadow_ident[SLOTS / 2], '0);
        // hold off until the table has answered everything
        drain_responses();
        id = shadow_ident[0];
        send_request(OP_ERASE, id, '0);
        send_request(OP_INJECT, fresh_ident(), random_value());
        send_request(OP_LIST, '0, '0);
    endtask

    task automatic test_random_traffic(input int n);
        logic [OPCODE_W-1:0]    op;
        logic [KEY_IDENT_W-1:0] id;
        for (int i = 0; i < n; i++)
        begin
            op = pick_opcode();
            id = pick_ident(op);
            send_request(op, id, pick_value(op, id));
        end
    endtask

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            shadow_ident[s] = '0;
            shadow_value[s] = '0;
        end
        shadow_count = 0;
        error_count  = 0;
        cycle_count  = 0;
        idle_pct     = 19;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_commands();
        test_table_full();
        test_random_traffic(128);
        idle_pct = 55;
        test_random_traffic(128);
        idle_pct = 0;
        test_random_traffic(128);

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_responses.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
